FILE: hdl/btmx_pkg.sv
// Package for the binary trie maximum-xor block.
// Holds operation and status codes shared by the interfaces and the top level.
// No dependencies.
package btmx_pkg;

	// Operation code carried with each request
	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_QUERY  = 1'b1
	} func_t;

	// Status code returned with each response
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	localparam int unsigned KeyPortBits = 32;

endpackage

FILE: hdl/btmx_in_if.sv
// Request channel of the binary trie maximum-xor block.
// Carries valid, ready, operation and key. Depends on btmx_pkg.
interface btmx_in_if import btmx_pkg::*; ();
	logic                   valid;
	logic                   ready;
	func_t                  func;
	logic [KeyPortBits-1:0] key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

FILE: hdl/btmx_out_if.sv
// Response channel of the binary trie maximum-xor block.
// Carries valid, ready, xor value and status. Depends on btmx_pkg.
interface btmx_out_if import btmx_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KeyPortBits-1:0] xor_value;
	status_t                status;

	modport source (output valid, output xor_value, output status, input ready);
	modport sink   (input valid, input xor_value, input status, output ready);
endinterface

FILE: hdl/btmx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btmx_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/binary_trie_max_xor.sv
// Top level of the binary trie maximum-xor block: insert keys, query max xor.
// Depends on btmx_pkg, btmx_in_if, btmx_out_if and btmx_ram.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   func, key
//   rsp      out  valid/ready   xor_value, status
//
// An insert or a query that walks the trie is taken in ST_IDLE, steps through
// ST_WALK one key bit at a time through the node memory read port (the next
// node address comes from the registered read of the current node), and loads
// its response in ST_FINISH. A refused insert or a query on an empty trie goes
// from ST_IDLE straight to ST_FINISH. Reset empties the trie at once; node
// memory needs no clearing pass, since a new node is known empty and its old
// entry is never used. A response not taken holds the walk in its last state;
// a new request is taken while the previous response still waits.
module binary_trie_max_xor import btmx_pkg::*; #(
	parameter int KEY_BITS   = 32,
	parameter int NODE_COUNT = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	btmx_in_if.sink         req,
	btmx_out_if.source      rsp
);

	localparam int AW = $clog2(NODE_COUNT);
	localparam int UW = $clog2(NODE_COUNT + 1);
	localparam int CW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam logic [UW-1:0] UsedLimit = UW'(NODE_COUNT - KEY_BITS);
	localparam logic [UW-1:0] UsedMax   = UW'(NODE_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t                state_q;
	func_t                 func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KEY_BITS-1:0]   xr_q;
	logic [CW-1:0]         cnt_q;
	logic [AW-1:0]         cur_q;
	logic                  fresh_q;
	logic [UW-1:0]         used_q;
	logic                  root_has_q;
	status_t               status_q;
	logic                  out_valid_q;
	logic [KeyPortBits-1:0] out_xor_q;
	status_t               out_status_q;

	logic [KEY_BITS-1:0]   key_ext;
	logic [2*AW-1:0]       rd_data;
	logic [2*AW-1:0]       wr_data;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         link0;
	logic [AW-1:0]         link1;
	logic [AW-1:0]         link_same;
	logic [AW-1:0]         link_opp;
	logic [AW-1:0]         new_idx;
	logic [AW-1:0]         next_cur;
	logic                  kbit;
	logic                  ins_miss;
	logic                  q_take_opp;
	logic                  q_dead;
	logic                  last_lvl;
	logic                  slot_free;

	// Node memory: one entry per node, {link for bit 1, link for bit 0}
	btmx_ram #(
		.WIDTH(2 * AW),
		.DEPTH(NODE_COUNT)
	) u_nodes (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cur_q),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Decode the current node; a fresh node has no children yet
	always_comb begin
		key_ext    = KEY_BITS'(req.key);
		link0      = fresh_q ? '0 : rd_data[AW-1:0];
		link1      = fresh_q ? '0 : rd_data[2*AW-1:AW];
		kbit       = key_q[cnt_q];
		link_same  = kbit ? link1 : link0;
		link_opp   = kbit ? link0 : link1;
		new_idx    = used_q[AW-1:0];
		ins_miss   = (link_same == '0);
		q_take_opp = (link_opp != '0);
		q_dead     = !q_take_opp && (link_same == '0);
		last_lvl   = (cnt_q == '0);
		slot_free  = !out_valid_q || rsp.ready;
		wr_en      = (state_q == ST_WALK) && (func_q == FUNC_INSERT) && ins_miss;
		wr_data    = kbit ? {new_idx, link0} : {link1, new_idx};
		if (func_q == FUNC_INSERT) begin
			next_cur = ins_miss ? new_idx : link_same;
		end else begin
			next_cur = q_take_opp ? link_opp : link_same;
		end
		rd_addr = (state_q == ST_WALK) ? next_cur : '0;
	end

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = out_valid_q;
	assign rsp.xor_value = out_xor_q;
	assign rsp.status    = out_status_q;

	// Sequencer: take request, walk one level per cycle, hand off response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= UW'(1);
			root_has_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			fresh_q      <= 1'b0;
			func_q       <= FUNC_INSERT;
			cnt_q        <= '0;
			cur_q        <= '0;
			xr_q         <= '0;
			key_q        <= '0;
			status_q     <= STATUS_OK;
			out_xor_q    <= '0;
			out_status_q <= STATUS_OK;
		end else begin
			// Drop the response once taken, unless the next one loads in its place
			if (out_valid_q && rsp.ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						func_q   <= req.func;
						key_q    <= key_ext;
						xr_q     <= '0;
						cnt_q    <= CW'(KEY_BITS - 1);
						cur_q    <= '0;
						fresh_q  <= !root_has_q;
						if (req.func == FUNC_INSERT && used_q > UsedLimit) begin
							status_q <= STATUS_FULL;
							state_q  <= ST_FINISH;
						end else if (req.func == FUNC_QUERY && !root_has_q) begin
							status_q <= STATUS_EMPTY;
							state_q  <= ST_FINISH;
						end else begin
							status_q <= STATUS_OK;
							state_q  <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					cur_q <= next_cur;
					cnt_q <= cnt_q - CW'(1);
					if (func_q == FUNC_INSERT) begin
						if (ins_miss) begin
							used_q  <= used_q + UW'(1);
							fresh_q <= 1'b1;
						end
						if (last_lvl) begin
							root_has_q <= 1'b1;
							state_q    <= ST_FINISH;
						end
					end else begin
						if (q_take_opp) begin
							xr_q[cnt_q] <= 1'b1;
						end
						if (last_lvl || q_dead) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					// Hold until the response register is free
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_xor_q    <= (func_q == FUNC_QUERY) ? KeyPortBits'(xr_q) : '0;
						out_status_q <= status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Node pool never overflows
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UsedMax)
		else $error("node pool count exceeds pool size");

	// Only an insert walk writes node memory
	a_write_insert: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_WALK) && (func_q == FUNC_INSERT))
		else $error("node write outside insert walk");

	// A write never lands on the node being fetched next
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cur_q != rd_addr))
		else $error("node write and read collide");

	// A query walk only runs on a non-empty trie
	a_query_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && func_q == FUNC_QUERY) |-> root_has_q)
		else $error("query walk on empty trie");

	// An insert that allocates moves the pool count by exactly one
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (used_q == $past(used_q) + UW'(1)))
		else $error("allocation did not advance pool count");

endmodule

FILE: tb/tb.sv
// Testbench for binary_trie_max_xor: inserts keys and checks maximum-xor query results.
// Depends on btmx_pkg, btmx_in_if, btmx_out_if and the RTL top level. A local trie
// predicts each response, which is checked in order as it is taken.
module tb import btmx_pkg::*; ();

	localparam int KEY_W        = 32;
	localparam int POOL_NODES   = 4096;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int SETTLE_TICKS = 2 * KEY_W + 8;

	typedef struct packed {
		logic [KEY_W-1:0] xor_value;
		status_t          status;
	} trie_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;
	int   ready_wait = 0;
	bit   no_gaps = 1'b0;
	int   error_count = 0;
	int   cycle_count = 0;

	// Local copy of the trie: two child links per node, 0 means no child
	logic [11:0]      child_of [POOL_NODES][2];
	int               nodes_used;
	bit               trie_loaded;
	logic [KEY_W-1:0] stored_keys [$];
	trie_result_t     pending_results [$];

	btmx_in_if  req_if ();
	btmx_out_if rsp_if ();

	assign rsp_if.ready = sink_ready;

	binary_trie_max_xor #(
		.KEY_BITS   (KEY_W),
		.NODE_COUNT (POOL_NODES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Empty the trie: only the root exists and it has no children
	function automatic void clear_trie();
		child_of[0][0] = '0;
		child_of[0][1] = '0;
		nodes_used = 1;
		trie_loaded = 1'b0;
		stored_keys.delete();
	endfunction

	// Apply one operation to the local trie and return the expected response
	function automatic trie_result_t predict_trie_result(input func_t f,
			input logic [KEY_W-1:0] k);
		trie_result_t r;
		int           cur;
		int           nxt;
		int           i;
		bit           stuck;
		logic         b;
		r.xor_value = '0;
		r.status = STATUS_OK;
		cur = 0;
		stuck = 1'b0;
		if (f == FUNC_INSERT) begin
			if (POOL_NODES - nodes_used < KEY_W) begin
				r.status = STATUS_FULL;
			end else begin
				for (i = KEY_W - 1; i >= 0; i--) begin
					b = k[i];
					nxt = int'(child_of[cur][b]);
					if (nxt == 0) begin
						nxt = nodes_used;
						child_of[nxt][0] = '0;
						child_of[nxt][1] = '0;
						nodes_used++;
						child_of[cur][b] = nxt[11:0];
					end
					cur = nxt;
				end
				trie_loaded = 1'b1;
				stored_keys.push_back(k);
			end
		end else if (!trie_loaded) begin
			r.status = STATUS_EMPTY;
		end else begin
			// Prefer the branch opposite the key bit at every level
			for (i = KEY_W - 1; i >= 0 && !stuck; i--) begin
				b = k[i];
				if (child_of[cur][~b] != 0) begin
					r.xor_value[i] = 1'b1;
					cur = int'(child_of[cur][~b]);
				end else if (child_of[cur][b] != 0) begin
					cur = int'(child_of[cur][b]);
				end else begin
					stuck = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// Drive one request, hold it until taken, then record its expected response
	task automatic send_op(input func_t f, input logic [KEY_W-1:0] k);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func <= f;
		req_if.key <= k;
		do @(posedge clk); while (!req_if.ready);
		pending_results.push_back(predict_trie_result(f, k));
	endtask

	// Hold off new requests until every response has come back
	task automatic drain_responses();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Take responses with random stalls and compare against the oldest expectation
	always @(posedge clk) begin
		trie_result_t want;
		int           w;
		if (!arst_n) begin
			sink_ready <= 1'b0;
			ready_wait <= 0;
		end else begin
			if (rsp_if.valid && sink_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected response xor=%h status=%0d",
						rsp_if.xor_value, rsp_if.status));
				end else begin
					want = pending_results.pop_front();
					if (rsp_if.xor_value !== want.xor_value)
						report_mismatch($sformatf("xor_value %h, expected %h",
							rsp_if.xor_value, want.xor_value));
					if (rsp_if.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp_if.status, want.status));
				end
				w = no_gaps ? 0 : $urandom_range(0, 3);
			end else if (ready_wait > 0) begin
				w = ready_wait - 1;
			end else begin
				w = 0;
			end
			ready_wait <= w;
			sink_ready <= (w == 0);
		end
	end

	// Queries before any insert report an empty trie
	task automatic test_empty_trie();
		send_op(FUNC_QUERY, '0);
		send_op(FUNC_QUERY, '1);
	endtask

	// Extreme keys, a duplicate insert and queries with alternating bit patterns
	task automatic test_extreme_keys();
		send_op(FUNC_INSERT, '0);
		send_op(FUNC_QUERY, '0);
		send_op(FUNC_QUERY, '1);
		send_op(FUNC_INSERT, '1);
		send_op(FUNC_QUERY, '0);
		send_op(FUNC_INSERT, '0);
		send_op(FUNC_INSERT, 32'h8000_0000);
		send_op(FUNC_INSERT, 32'h7fff_ffff);
		send_op(FUNC_INSERT, 32'h0000_0001);
		send_op(FUNC_QUERY, 32'h5555_5555);
		send_op(FUNC_QUERY, 32'haaaa_aaaa);
		send_op(FUNC_QUERY, 32'h8000_0000);
		send_op(FUNC_QUERY, 32'h7fff_ffff);
		drain_responses();
	endtask

	// Mixed traffic; clustered keys share long prefixes so the pool fills slowly
	task automatic test_random_traffic(input int count, input int insert_pct);
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] cluster_hi;
		int               i;
		cluster_hi = $urandom();
		for (i = 0; i < count; i++) begin
			if (i % 64 == 0) begin
				no_gaps = ($urandom_range(0, 3) == 0);
				cluster_hi = $urandom();
			end
			k = $urandom();
			if ($urandom_range(1, 100) <= insert_pct) begin
				case ($urandom_range(0, 3))
					1, 2: k = {cluster_hi[KEY_W-1:10], 10'($urandom())};
					3: if (stored_keys.size() != 0)
						k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
					default: ;
				endcase
				send_op(FUNC_INSERT, k);
			end else begin
				case ($urandom_range(0, 3))
					1: if (stored_keys.size() != 0)
						k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
					2: if (stored_keys.size() != 0)
						k = ~stored_keys[$urandom_range(0, stored_keys.size() - 1)];
					3: k = {cluster_hi[KEY_W-1:10], 10'($urandom())};
					default: ;
				endcase
				send_op(FUNC_QUERY, k);
			end
		end
		no_gaps = 1'b0;
	endtask

	// Fill the node pool with spread-out keys, then check that inserts are refused
	task automatic test_pool_exhaust();
		logic [KEY_W-1:0] k;
		while (POOL_NODES - nodes_used >= KEY_W) begin
			send_op(FUNC_INSERT, $urandom());
		end
		drain_responses();
		k = stored_keys[0];
		send_op(FUNC_INSERT, k);
		send_op(FUNC_INSERT, ~k);
		send_op(FUNC_QUERY, k);
		send_op(FUNC_QUERY, ~k);
		send_op(FUNC_INSERT, '1);
		send_op(FUNC_QUERY, $urandom());
	endtask

	initial begin
		req_if.valid <= 1'b0;
		req_if.func <= FUNC_INSERT;
		req_if.key <= '0;
		clear_trie();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_trie();
		test_extreme_keys();
		test_random_traffic(550, 30);
		test_pool_exhaust();
		test_random_traffic(400, 40);

		// Wait out the last responses, then let any stray output show
		drain_responses();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/btmx_pkg.sv
hdl/btmx_in_if.sv
hdl/btmx_out_if.sv
hdl/btmx_ram.sv
hdl/binary_trie_max_xor.sv
tb/tb.sv
